// ===== rtl/core/priority_queues_round_robin_dispatch_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the priority queue dispatch block
// Concurrent checks on the block clock, disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_QUEUES_ROUND_ROBIN_DISPATCH_DEFINES_SVH
`define PRIORITY_QUEUES_ROUND_ROBIN_DISPATCH_DEFINES_SVH

// condition implies consequence in the same cycle
`define PRQD_ASSERT_NOW(lbl, cond, conseq, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error(msg);

// condition implies consequence in the next cycle
`define PRQD_ASSERT_NEXT(lbl, cond, conseq, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error(msg);

`endif

// ===== rtl/core/prqd_pkg.sv =====
// ----------------------------------------------------------------------------
// prqd_pkg
// Types and codes shared by the priority queue dispatch modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package prqd_pkg;

  localparam int ENTRY_W = 32;

  localparam logic MODE_ENQ = 1'b0;
  localparam logic MODE_DEQ = 1'b1;

  typedef enum logic [1:0] {
    ST_ENQ   = 2'd0,
    ST_DEQ   = 2'd1,
    ST_EMPTY = 2'd2,
    ST_DROP  = 2'd3
  } status_t;

  typedef struct packed {
    logic        mode;
    logic [1:0]  priority_req;
    logic [15:0] msg_handle;
    logic [15:0] sub_id;
    logic        dequeue_queue;
  } item_t;

  typedef struct packed {
    status_t     status;
    logic        queue_used;
    logic [1:0]  out_priority;
    logic [15:0] out_handle;
    logic [15:0] out_subscriber;
  } result_t;

  typedef struct packed {
    status_t    status;
    logic       queue_used;
    logic [1:0] out_priority;
  } resp_hdr_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_flags_t;

endpackage

// ===== rtl/core/priority_queues_round_robin_dispatch.sv =====
// ----------------------------------------------------------------------------
// priority_queues_round_robin_dispatch
// Round-robin enqueue over NUM_QUEUES strict-priority queues, with dequeue
// from the lowest-numbered non-empty priority FIFO of a named queue.
// ----------------------------------------------------------------------------
// One item is taken per cycle (start high, busy low); busy is high only
// during reset and the cycle after it. Each item gives one result, shown for
// exactly one cycle with done high, once the item has passed the input
// register and then the pointer update and the registered read of the
// entry RAM. The receiver cannot stall, so results must be captured
// when done is high. Entries live in one RAM of
// NUM_QUEUES*PRIORITY_LEVELS*FIFO_DEPTH words that needs no clearing pass.
`timescale 1ns / 1ps
`include "priority_queues_round_robin_dispatch_defines.svh"

module priority_queues_round_robin_dispatch #(
  parameter int NUM_QUEUES      = 2,
  parameter int PRIORITY_LEVELS = 4,
  parameter int FIFO_DEPTH      = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  prqd_pkg::item_t   item,
  output logic              done,
  output prqd_pkg::result_t result
);

  import prqd_pkg::*;

  localparam int NF = NUM_QUEUES * PRIORITY_LEVELS;
  localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int PW = $clog2(FIFO_DEPTH);
  localparam int AW = $clog2(NF * FIFO_DEPTH);

  logic            in_valid;
  item_t           in_item;
  logic [QW-1:0]   rr;
  logic [QW-1:0]   rr_next;

  fifo_flags_t     flags [NF];
  logic [PW-1:0]   heads [NF];
  logic [PW-1:0]   tails [NF];
  logic [NF-1:0]   push;
  logic [NF-1:0]   pop;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic            ram_re;
  logic [AW-1:0]   ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;

  resp_hdr_t       hdr_next;
  resp_hdr_t       hdr;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      in_valid <= 1'b0;
      done     <= 1'b0;
      rr       <= '0;
    end else begin
      busy     <= 1'b0;
      in_valid <= start && !busy;
      done     <= in_valid;
      if (in_valid && in_item.mode == MODE_ENQ) begin
        rr <= rr_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    in_item <= item;
    hdr     <= hdr_next;
  end

  for (genvar g = 0; g < NF; g++) begin : g_fifo
    prqd_fifo_ctrl #(
      .DEPTH(FIFO_DEPTH)
    ) u_fifo (
      .clk  (clk),
      .rst  (rst),
      .push (push[g]),
      .pop  (pop[g]),
      .flags(flags[g]),
      .head (heads[g]),
      .tail (tails[g])
    );
  end

  prqd_dispatch #(
    .NUM_QUEUES     (NUM_QUEUES),
    .PRIORITY_LEVELS(PRIORITY_LEVELS),
    .FIFO_DEPTH     (FIFO_DEPTH)
  ) u_dispatch (
    .valid    (in_valid),
    .item     (in_item),
    .rr       (rr),
    .flags    (flags),
    .heads    (heads),
    .tails    (tails),
    .rr_next  (rr_next),
    .push     (push),
    .pop      (pop),
    .ram_we   (ram_we),
    .ram_waddr(ram_waddr),
    .ram_wdata(ram_wdata),
    .ram_re   (ram_re),
    .ram_raddr(ram_raddr),
    .hdr      (hdr_next)
  );

  prqd_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(NF * FIFO_DEPTH)
  ) u_entry_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    result.status       = hdr.status;
    result.queue_used   = hdr.queue_used;
    result.out_priority = hdr.out_priority;
    if (hdr.status == ST_DEQ) begin
      result.out_handle     = ram_rdata[15:0];
      result.out_subscriber = ram_rdata[31:16];
    end else begin
      result.out_handle     = '0;
      result.out_subscriber = '0;
    end
  end

  `PRQD_ASSERT_NEXT(a_done_follows, in_valid, done, "accepted item produced no result")
  `PRQD_ASSERT_NOW(a_push_pop_excl, 1'b1, $onehot0({push, pop}), "multiple FIFO updates")
  `PRQD_ASSERT_NOW(a_deq_read, done && result.status == ST_DEQ, $past(ram_re), "no RAM read")
  `PRQD_ASSERT_NOW(a_enq_write, in_valid && hdr_next.status == ST_ENQ, ram_we, "enqueue not written")

endmodule

// ===== rtl/core/prqd_ram.sv =====
// ----------------------------------------------------------------------------
// prqd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module prqd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/prqd_fifo_ctrl.sv =====
// ----------------------------------------------------------------------------
// prqd_fifo_ctrl
// Head, tail and fill count of one priority FIFO.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module prqd_fifo_ctrl #(
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  logic                     pop,
  output prqd_pkg::fifo_flags_t    flags,
  output logic [$clog2(DEPTH)-1:0] head,
  output logic [$clog2(DEPTH)-1:0] tail
);

  import prqd_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0] count;

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail <= wrap_inc(tail);
      end
      if (pop) begin
        head <= wrap_inc(head);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  assign flags.empty = (count == '0);
  assign flags.full  = (count == CW'(DEPTH));

endmodule

// ===== rtl/core/prqd_dispatch.sv =====
// ----------------------------------------------------------------------------
// prqd_dispatch
// Decodes one registered item: round-robin target, priority pick, FIFO
// push/pop, entry RAM access and the result header.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module prqd_dispatch #(
  parameter int NUM_QUEUES      = 2,
  parameter int PRIORITY_LEVELS = 4,
  parameter int FIFO_DEPTH      = 16
) (
  input  logic                  valid,
  input  prqd_pkg::item_t       item,
  input  logic [((NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1)-1:0] rr,
  input  prqd_pkg::fifo_flags_t flags [NUM_QUEUES*PRIORITY_LEVELS],
  input  logic [$clog2(FIFO_DEPTH)-1:0] heads [NUM_QUEUES*PRIORITY_LEVELS],
  input  logic [$clog2(FIFO_DEPTH)-1:0] tails [NUM_QUEUES*PRIORITY_LEVELS],
  output logic [((NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1)-1:0] rr_next,
  output logic [NUM_QUEUES*PRIORITY_LEVELS-1:0] push,
  output logic [NUM_QUEUES*PRIORITY_LEVELS-1:0] pop,
  output logic                  ram_we,
  output logic [$clog2(NUM_QUEUES*PRIORITY_LEVELS*FIFO_DEPTH)-1:0] ram_waddr,
  output logic [prqd_pkg::ENTRY_W-1:0] ram_wdata,
  output logic                  ram_re,
  output logic [$clog2(NUM_QUEUES*PRIORITY_LEVELS*FIFO_DEPTH)-1:0] ram_raddr,
  output prqd_pkg::resp_hdr_t   hdr
);

  import prqd_pkg::*;

  localparam int NF = NUM_QUEUES * PRIORITY_LEVELS;
  localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int LW = (PRIORITY_LEVELS > 1) ? $clog2(PRIORITY_LEVELS) : 1;
  localparam int FW = (NF > 1) ? $clog2(NF) : 1;
  localparam int PW = $clog2(FIFO_DEPTH);
  localparam int AW = $clog2(NF * FIFO_DEPTH);

  function automatic logic [AW-1:0] slot_addr(input logic [FW-1:0] f,
                                               input logic [PW-1:0] p);
    return AW'(int'(f) * FIFO_DEPTH + int'(p));
  endfunction

  function automatic logic [FW-1:0] fifo_idx(input logic [QW-1:0] q,
                                             input logic [LW-1:0] l);
    return FW'(int'(q) * PRIORITY_LEVELS + int'(l));
  endfunction

  logic [QW-1:0] q;
  logic [LW-1:0] lvl;
  logic [LW-1:0] sel;
  logic          hit;
  logic [FW-1:0] fe;
  logic [FW-1:0] fs;

  assign rr_next = (int'(rr) + 1 >= NUM_QUEUES) ? '0 : rr + QW'(1);

  always_comb begin
    if (32'(item.priority_req) >= PRIORITY_LEVELS) begin
      lvl = LW'(PRIORITY_LEVELS - 1);
    end else begin
      lvl = LW'(item.priority_req);
    end
    if (item.mode == MODE_DEQ) begin
      q = (32'(item.dequeue_queue) >= NUM_QUEUES) ? '0 : QW'(item.dequeue_queue);
    end else begin
      q = rr;
    end

    // lowest non-empty level wins
    hit = 1'b0;
    sel = '0;
    for (int i = PRIORITY_LEVELS - 1; i >= 0; i--) begin
      if (!flags[fifo_idx(q, LW'(i))].empty) begin
        hit = 1'b1;
        sel = LW'(i);
      end
    end

    fe = fifo_idx(q, lvl);
    fs = fifo_idx(q, sel);
  end

  always_comb begin
    push      = '0;
    pop       = '0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = slot_addr(fe, tails[fe]);
    ram_raddr = slot_addr(fs, heads[fs]);
    ram_wdata = {item.sub_id, item.msg_handle};
    hdr.status       = ST_ENQ;
    hdr.queue_used   = q[0];
    hdr.out_priority = 2'b00;
    if (item.mode == MODE_ENQ) begin
      if (flags[fe].full) begin
        hdr.status = ST_DROP;
      end else begin
        push[fe] = valid;
        ram_we   = valid;
      end
    end else begin
      if (hit) begin
        pop[fs]          = valid;
        ram_re           = valid;
        hdr.status       = ST_DEQ;
        hdr.out_priority = 2'(32'(sel));
      end else begin
        hdr.status = ST_EMPTY;
      end
    end
  end

endmodule
